// ===== rtl/core/b85_pkg.sv =====
// ----------------------------------------------------------------------------
// b85_pkg
// shared types, constants and helpers of the base-85 stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b85_pkg;

	// character classes
	localparam logic [7:0] FIRST_DIGIT = 8'd33;   // '!'
	localparam logic [7:0] LAST_DIGIT  = 8'd117;  // 'u'
	localparam logic [7:0] CHAR_SPACE  = 8'd32;
	localparam logic [7:0] CHAR_TAB    = 8'd9;
	localparam logic [7:0] CHAR_CR     = 8'd13;

	// digits per group, and the count at which a new digit closes the group
	localparam int unsigned GROUP_DIGITS = 5;
	localparam logic [2:0]  LAST_SLOT    = 3'(GROUP_DIGITS - 1);
	localparam logic [2:0]  MIN_FLUSH    = 3'd2;

	// default depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// result status codes
	typedef enum logic [1:0] {
		ST_BYTE     = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// work handed from front to back
	typedef enum logic [1:0] {
		CMD_BYTES,
		CMD_INVALID,
		CMD_OVERFLOW
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [32:0] value;     // finished group, bit 32 set on overflow
		logic [1:0]  last_idx;  // index of the final byte to emit
	} cmd_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       flush;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		status_t    status;
		logic       last_of_run;
	} out_word_t;

	// 85^(5-k): scale of a partial group of k digits padded with 'u'
	function automatic logic [19:0] pad_scale(input logic [2:0] count);
		logic [19:0] scale;
		case (count)
			3'd2:    scale = 20'd614125;
			3'd3:    scale = 20'd7225;
			3'd4:    scale = 20'd85;
			default: scale = 20'd1;
		endcase
		return scale;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base85_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base85_stream_decoder
// base-85 text to byte stream decoder with error and overflow reporting
// ----------------------------------------------------------------------------
// usage
//   sym channel: one character word per handshake (sym_valid high, sym_stall
//   low); sym.flush marks end of stream and pads a partial group with 'u'
//   res channel: one result word per handshake; res.last_of_run closes the
//   results that one input word caused (up to four bytes, or one error)
//   the front takes a word every cycle while the command queue has room, so
//   sym_stall only rises when the queue is full
//   a word's command passes through the queue and then the registered output;
//   the back gives one result per cycle while res_stall is low, which is the
//   sustained rate (five characters give four bytes, so the output keeps up)
//   a flush after a partial group goes through one 27x20 multiply in the front
//   reset: group, digit count, error flag, queue count and output valid clear
//   receiver stall: the result holds, the back stops, the queue fills, and
//   then sym_stall rises; nothing is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module base85_stream_decoder #(
	parameter int unsigned QueueDepth = b85_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sym_valid,
	output logic               sym_stall,
	input  b85_pkg::in_word_t  sym,
	output logic               res_valid,
	input  logic               res_stall,
	output b85_pkg::out_word_t res
);

	// front to queue
	logic          cmd_push;
	b85_pkg::cmd_t cmd_in;

	// queue to back
	b85_pkg::cmd_t cmd_head;
	logic          cmd_pop;
	logic          fifo_full;
	logic          fifo_empty;

	// stall the sender only when there is no room for a command
	assign sym_stall = fifo_full;

	// character classification and group accumulation
	b85_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym       (sym),
		.full      (fifo_full),
		.push      (cmd_push),
		.cmd       (cmd_in)
	);

	// decouples the front from a stalled output
	b85_cmd_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.head   (cmd_head),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// byte emission into the registered output
	b85_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (fifo_empty),
		.head      (cmd_head),
		.pop       (cmd_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// the front never writes a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_full)
		else $error("command pushed into full queue");

	// the back never retires a command that is not there
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !fifo_empty)
		else $error("command popped from empty queue");

	// error results are single, zero-data words
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != b85_pkg::ST_BYTE)) |->
		(res.last_of_run && (res.data_byte == 8'd0)))
		else $error("error result with data or without last_of_run");

endmodule

`default_nettype wire

// ===== rtl/core/b85_front.sv =====
// ----------------------------------------------------------------------------
// b85_front
// accepts characters, gathers digit groups and queues finished work
// ----------------------------------------------------------------------------
`default_nettype none

module b85_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	input  b85_pkg::in_word_t sym,
	input  logic              full,
	output logic              push,
	output b85_pkg::cmd_t     cmd
);

	logic [25:0] group_q, group_d;
	logic [2:0]  count_q, count_d;
	logic        err_q, err_d;

	logic        accept;
	logic [7:0]  diff;
	logic [32:0] g33;
	logic [32:0] grown;
	logic [26:0] g_inc;
	logic [46:0] prod;
	logic [32:0] padded;
	logic [2:0]  flush_idx;
	logic        is_digit;
	logic        is_space;

	assign accept   = sym_valid && !full;
	assign diff     = sym.symbol - b85_pkg::FIRST_DIGIT;
	assign is_digit = (sym.symbol >= b85_pkg::FIRST_DIGIT) &&
	                  (sym.symbol <= b85_pkg::LAST_DIGIT);
	assign is_space = (sym.symbol == b85_pkg::CHAR_SPACE) ||
	                  ((sym.symbol >= b85_pkg::CHAR_TAB) && (sym.symbol <= b85_pkg::CHAR_CR));

	// group * 85 + digit as shift-add
	assign g33   = {7'd0, group_q};
	assign grown = (g33 << 6) + (g33 << 4) + (g33 << 2) + g33 + {26'd0, diff[6:0]};

	// padded partial group: (g + 1) * 85^(5-k) - 1
	assign g_inc     = {1'b0, group_q} + 27'd1;
	assign prod      = g_inc * b85_pkg::pad_scale(count_q);
	assign padded    = prod[32:0] - 33'd1;
	assign flush_idx = count_q - b85_pkg::MIN_FLUSH;

	always_comb begin
		push          = 1'b0;
		cmd.kind      = b85_pkg::CMD_INVALID;
		cmd.value     = '0;
		cmd.last_idx  = '0;
		group_d       = group_q;
		count_d       = count_q;
		err_d         = err_q;
		if (accept) begin
			if (sym.flush) begin
				if (!err_q && (count_q >= b85_pkg::MIN_FLUSH)) begin
					push         = 1'b1;
					cmd.kind     = padded[32] ? b85_pkg::CMD_OVERFLOW : b85_pkg::CMD_BYTES;
					cmd.value    = padded;
					// an overflow is a single word
					cmd.last_idx = padded[32] ? 2'd0 : flush_idx[1:0];
				end
				group_d = '0;
				count_d = '0;
				err_d   = 1'b0;
			end else if (!err_q) begin
				if (is_digit) begin
					if (count_q == b85_pkg::LAST_SLOT) begin
						push         = 1'b1;
						cmd.kind     = grown[32] ? b85_pkg::CMD_OVERFLOW : b85_pkg::CMD_BYTES;
						cmd.value    = grown;
						cmd.last_idx = grown[32] ? 2'd0 : 2'd3;
						group_d      = '0;
						count_d      = '0;
						err_d        = grown[32];
					end else begin
						group_d = grown[25:0];
						count_d = count_q + 3'd1;
					end
				end else if (!is_space) begin
					push     = 1'b1;
					cmd.kind = b85_pkg::CMD_INVALID;
					group_d  = '0;
					count_d  = '0;
					err_d    = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else begin
			group_q <= group_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/b85_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// b85_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module b85_cmd_fifo #(
	parameter int unsigned Depth = b85_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  b85_pkg::cmd_t wdata,
	input  logic          pop,
	output b85_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	b85_pkg::cmd_t  mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/b85_back.sv =====
// ----------------------------------------------------------------------------
// b85_back
// walks queued groups one byte a cycle, while the output is not stalled, into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module b85_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  b85_pkg::cmd_t      head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output b85_pkg::out_word_t res
);

	logic               res_valid_q;
	b85_pkg::out_word_t res_q;
	logic [1:0]         idx_q;

	logic               out_free;
	logic               emit;
	logic               is_last;
	logic [7:0]         byte_sel;
	b85_pkg::out_word_t word_d;

	assign out_free = !res_valid_q || !res_stall;
	assign emit     = !empty && out_free;
	assign is_last  = (idx_q == head.last_idx);
	assign pop      = emit && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = head.value[31:24];
			2'd1:    byte_sel = head.value[23:16];
			2'd2:    byte_sel = head.value[15:8];
			default: byte_sel = head.value[7:0];
		endcase
	end

	always_comb begin
		word_d.last_of_run = is_last;
		unique case (head.kind)
			b85_pkg::CMD_BYTES: begin
				word_d.data_byte = byte_sel;
				word_d.status    = b85_pkg::ST_BYTE;
			end
			b85_pkg::CMD_OVERFLOW: begin
				word_d.data_byte = '0;
				word_d.status    = b85_pkg::ST_OVERFLOW;
			end
			default: begin
				word_d.data_byte = '0;
				word_d.status    = b85_pkg::ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_free) begin
				res_valid_q <= emit;
			end
			if (emit) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= word_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== tb/base85_stream_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// base85_stream_decoder_tb
// self-checking bench: base-85 characters in, decoded bytes and errors out
// ----------------------------------------------------------------------------
// a queue of character and flush words feeds a bursty sender; every accepted
// word runs through a behavioral decoder that predicts the result words, and
// the monitor compares each accepted result with the oldest prediction while
// the receiver stalls on a pattern of its own
// ----------------------------------------------------------------------------
`default_nettype none

module base85_stream_decoder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 12;     // room for any stray result to show
	localparam int unsigned RANDOM_WORDS = 64;
	localparam logic [7:0]  PAD_DIGIT    = b85_pkg::LAST_DIGIT - b85_pkg::FIRST_DIGIT;
	localparam logic [63:0] GROUP_MAX    = 64'hFFFF_FFFF;

	// receiver stall patterns, stepped through as the run goes on
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               sym_valid = 1'b0;
	logic               sym_stall;
	b85_pkg::in_word_t  sym       = '0;
	logic               res_valid;
	logic               res_stall = 1'b1;
	b85_pkg::out_word_t res;

	base85_stream_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym       (sym),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #10 clk = ~clk;

	// words waiting to be sent, and result words the decoder still owes
	b85_pkg::in_word_t  char_queue[$];
	b85_pkg::out_word_t decoded_fifo[$];

	// behavioral copy of the decoder state
	logic [32:0] group_acc  = '0;
	logic [2:0]  digits_held = '0;
	logic        in_error   = 1'b0;

	int unsigned        cycle_count   = 0;
	int unsigned        error_count   = 0;
	int unsigned        words_queued  = 0;   // flushes and non-blank characters queued
	int unsigned        words_in      = 0;
	int unsigned        flushes_in    = 0;
	int unsigned        bytes_out     = 0;
	int unsigned        invalid_out   = 0;
	int unsigned        overflow_out  = 0;
	int                 burst_left    = 1;
	int                 gap_left      = 0;
	stall_mode_t        stall_mode;
	b85_pkg::out_word_t want;

	function automatic bit is_blank(input logic [7:0] c);
		return c == b85_pkg::CHAR_SPACE ||
			(c >= b85_pkg::CHAR_TAB && c <= b85_pkg::CHAR_CR);
	endfunction

	// a finished or padded group: its leading bytes, or one overflow word
	task automatic split_group(input logic [63:0] g, input int nbytes);
		b85_pkg::out_word_t r;
		int                 i;
		if (g > GROUP_MAX) begin
			in_error      = 1'b1;
			r.data_byte   = 8'd0;
			r.status      = b85_pkg::ST_OVERFLOW;
			r.last_of_run = 1'b1;
			decoded_fifo.push_back(r);
		end else begin
			for (i = 0; i < nbytes; i++) begin
				r.data_byte   = 8'(g >> ((3 - i) * 8));
				r.status      = b85_pkg::ST_BYTE;
				r.last_of_run = (i == nbytes - 1);
				decoded_fifo.push_back(r);
			end
		end
	endtask

	// predicts the result words of one accepted word
	task automatic decode_char(input b85_pkg::in_word_t w);
		logic [63:0]        g;
		b85_pkg::out_word_t r;
		int                 k;
		if (w.flush) begin
			// a lone digit holds no whole byte, and a flush in error says nothing
			if (!in_error && digits_held >= b85_pkg::MIN_FLUSH &&
				digits_held < b85_pkg::GROUP_DIGITS) begin
				g = 64'(group_acc);
				for (k = int'(digits_held); k < b85_pkg::GROUP_DIGITS; k++)
					g = g * 64'd85 + 64'(PAD_DIGIT);
				split_group(g, int'(digits_held) - 1);
			end
			group_acc   = '0;
			digits_held = '0;
			in_error    = 1'b0;
		end else if (!in_error) begin
			if (w.symbol >= b85_pkg::FIRST_DIGIT && w.symbol <= b85_pkg::LAST_DIGIT) begin
				group_acc   = group_acc * 33'd85 + 33'(w.symbol - b85_pkg::FIRST_DIGIT);
				digits_held = digits_held + 3'd1;
				if (digits_held == b85_pkg::GROUP_DIGITS) begin
					g           = 64'(group_acc);
					group_acc   = '0;
					digits_held = '0;
					split_group(g, 4);
				end
			end else if (!is_blank(w.symbol)) begin
				// bad character drops the partial group and latches the error
				in_error      = 1'b1;
				group_acc     = '0;
				digits_held   = '0;
				r.data_byte   = 8'd0;
				r.status      = b85_pkg::ST_INVALID;
				r.last_of_run = 1'b1;
				decoded_fifo.push_back(r);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------------

	task automatic queue_word(input logic [7:0] c, input logic fl);
		b85_pkg::in_word_t w;
		w.symbol = c;
		w.flush  = fl;
		char_queue.push_back(w);
		if (fl || !is_blank(c))
			words_queued++;
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_word(s[i], 1'b0);
	endtask

	// n random digits with stray whitespace, optionally closed by a flush
	task automatic queue_group(input int n, input bit close);
		int k;
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				k = $urandom_range(0, 5);
				queue_word((k == 5) ? b85_pkg::CHAR_SPACE : b85_pkg::CHAR_TAB + 8'(k), 1'b0);
			end
			queue_word(8'($urandom_range(b85_pkg::FIRST_DIGIT, b85_pkg::LAST_DIGIT)), 1'b0);
		end
		if (close)
			queue_word(8'($urandom), 1'b1);
	endtask

	// mostly well-formed groups, some partial groups and flushes, a little noise
	task automatic queue_random_until(input int unsigned goal);
		int unsigned pick;
		while (words_queued < goal) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				queue_group(5, 1'b0);
			end else if (pick <= 7) begin
				queue_group($urandom_range(1, 4), 1'b1);
			end else if (pick == 8) begin
				queue_word(8'($urandom_range(0, 255)), 1'b0);
				if ($urandom_range(0, 3) != 0)
					queue_word(8'($urandom), 1'b1);
			end else begin
				queue_word(8'($urandom), 1'b1);
			end
		end
	endtask

	// hold the sender until the block has handed back everything it owes
	task automatic wait_drained();
		while (char_queue.size() != 0 || sym_valid || decoded_fifo.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words
		queue_word(8'hFF, 1'b1);                       // flush with nothing held, symbol ignored
		queue_text("s\0118\012 W\013-\014!\015");      // all-ones group, every blank code between
		queue_text("uu");                              // two digits padded past the top
		queue_word(8'h00, 1'b1);
		queue_text("!!!!");                            // four digits flush into three bytes
		queue_word(8'h5A, 1'b1);
		queue_text("uuuuu~ ");                         // full group overflows, rest is ignored
		queue_word(8'h00, 1'b1);                       // flush leaves the error state silently
		queue_text("!");                               // one digit: nothing to emit
		queue_word(8'h80, 1'b1);
		queue_text("z");                               // shorthand zero is not supported
		queue_word(8'h21, 1'b1);
		queue_text("v");                               // just past the digit range
		queue_word(8'h7F, 1'b1);
		wait_drained();

		// random part in two rounds, with a full drain between them
		queue_random_until(words_queued + RANDOM_WORDS / 2);
		wait_drained();
		queue_random_until(words_queued + RANDOM_WORDS - RANDOM_WORDS / 2);
		wait_drained();

		$display("covered %0d input words (%0d flushes) over %0d cycles",
			words_in, flushes_in, cycle_count);
		$display("checked %0d bytes, %0d invalid-character and %0d overflow words",
			bytes_out, invalid_out, overflow_out);
		if (error_count == 0) begin
			$display("base85_stream_decoder: match");
		end else begin
			$display("base85_stream_decoder: mismatch");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// sender: bursts of words with random gaps between them
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		// the payload only moves once the current word is taken
		if (arst_n && (!sym_valid || !sym_stall)) begin
			if (gap_left > 0) begin
				gap_left  = gap_left - 1;
				sym_valid <= 1'b0;
			end else if (char_queue.size() == 0) begin
				sym_valid <= 1'b0;
			end else begin
				sym       <= char_queue.pop_front();
				sym_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: stall pattern taken from bits 9:8 of the count of elapsed cycles
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		stall_mode = stall_mode_t'(cycle_count[9:8]);
		case (stall_mode)
			STALL_NONE:     res_stall <= 1'b0;
			STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: res_stall <= ((cycle_count % 11) < 4);
			default:        res_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// ------------------------------------------------------------------------
	// monitor: predict on every accepted word, check every accepted result
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (sym_valid && !sym_stall) begin
				decode_char(sym);
				words_in++;
				if (sym.flush)
					flushes_in++;
			end
			if (res_valid && !res_stall) begin
				if (decoded_fifo.size() == 0) begin
					$error("result word with none expected: data_byte %0h status %0d last %0b",
						res.data_byte, res.status, res.last_of_run);
					error_count++;
				end else begin
					want = decoded_fifo.pop_front();
					if (res.data_byte !== want.data_byte) begin
						$error("data_byte: expected %0h, got %0h", want.data_byte, res.data_byte);
						error_count++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						error_count++;
					end
					if (res.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							want.last_of_run, res.last_of_run);
						error_count++;
					end
					case (want.status)
						b85_pkg::ST_BYTE:    bytes_out++;
						b85_pkg::ST_INVALID: invalid_out++;
						default:             overflow_out++;
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("base85_stream_decoder: mismatch");
			$finish;
		end
	end

endmodule

`default_nettype wire
